>>> hw/rtl/gpmtz_pkg.sv
// Shared constants and types for the grid path trailing-zero block.
package gpmtz_pkg;

    localparam int MAX_N      = 32;
    localparam int VALUE_BITS = 30;
    localparam int CFG_W      = 6;
    localparam int SUM_W      = 11;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int IDX_W      = $clog2(MAX_N);
    localparam int MV_W       = $clog2(2 * MAX_N - 1);
    localparam int STK_DEPTH  = 2 * MAX_N - 2;
    localparam int STK_AW     = $clog2(STK_DEPTH);
    localparam int CFL_DEPTH  = 1 << (2 * IDX_W);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Inverse of 5 modulo 2^VALUE_BITS, and the largest exact quotient.
    localparam logic [31:0] INV5_32 = 32'hCCCC_CCCD;
    localparam logic [VALUE_BITS-1:0] INV5 = INV5_32[VALUE_BITS-1:0];
    localparam logic [VALUE_BITS-1:0] DIV5_LIM =
        VALUE_BITS'(((64'd1 << VALUE_BITS) - 64'd1) / 64'd5);

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] twos;
        logic [CNT_W-1:0] fives;
    } t_fac_res;

endpackage

>>> hw/rtl/gpmtz_factor.sv
// Iterative counter of the factors of 2 and 5 in one cell value.
module gpmtz_factor
    import gpmtz_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    output t_fac_res              o_res
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_TWOS  = 3'b010,
        F_FIVES = 3'b100
    } t_fstate;

    t_fstate                 r_state, n_state;
    logic [VALUE_BITS-1:0]   r_t, n_t;
    logic [CNT_W-1:0]        r_tw, n_tw;
    logic [CNT_W-1:0]        r_fv, n_fv;
    logic                    r_done, n_done;
    logic [VALUE_BITS-1:0]   w_q;

    // exact division by 5 through the modular inverse, low bits only
    assign w_q = r_t * INV5;

    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        n_tw    = r_tw;
        n_fv    = r_fv;
        n_done  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    if (i_value == '0) begin
                        // zero cell costs one of each
                        n_tw   = CNT_W'(1);
                        n_fv   = CNT_W'(1);
                        n_done = 1'b1;
                    end else begin
                        n_t     = i_value;
                        n_tw    = '0;
                        n_fv    = '0;
                        n_state = F_TWOS;
                    end
                end
            end
            F_TWOS: begin
                if (!r_t[0]) begin
                    n_t  = r_t >> 1;
                    n_tw = r_tw + CNT_W'(1);
                end else begin
                    n_state = F_FIVES;
                end
            end
            F_FIVES: begin
                if (w_q <= DIV5_LIM) begin
                    n_t  = w_q;
                    n_fv = r_fv + CNT_W'(1);
                end else begin
                    n_done  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t  <= n_t;
        r_tw <= n_tw;
        r_fv <= n_fv;
    end

    assign o_res.done  = r_done;
    assign o_res.twos  = r_tw;
    assign o_res.fives = r_fv;

endmodule

>>> hw/rtl/grid_path_min_trailing_zeros.sv
// Least-trailing-zero right/down path over an n-by-n grid, top level.
//
// Cells arrive one per transfer in row-major order; grid_size (1..32, 0 acts
// as 1, larger acts as 32) sets n, and writing it restarts the grid being
// received. Each cell goes through an iterative factor unit that shifts out
// one factor of 2 per cycle, then strips one factor of 5 per cycle with a
// multiply by the inverse of 5; the input is not ready until a cell's factor
// counts are done, and a zero cell skips both loops.
// After the last cell the block traces the stored predecessor bits back from
// the bottom-right cell, one memory read and one step per move, and then
// emits one result per move while the output register is free, or a single
// result for a one-cell grid. A zero-cell path (answer 1) skips the trace.
// The input is not ready from the end of a grid until its last result has
// been placed in the output register; that register lets the next grid's
// cells flow while the final result still waits to be taken.
module grid_path_min_trailing_zeros
    import gpmtz_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_BITS-1:0] i_cell_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SUM_W-1:0]      o_zero_count,
    output logic                  o_move,
    output logic                  o_move_valid,
    output logic                  o_last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FACT  = 6'b000010,
        S_TR_RD = 6'b000100,
        S_TR_ST = 6'b001000,
        S_EM_RD = 6'b010000,
        S_EM_LD = 6'b100000
    } t_state;

    // control
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_grid_size, n_grid_size;
    logic [IDX_W-1:0]   r_row, n_row, r_col, n_col;
    logic [SUM_W-1:0]   r_left2, n_left2, r_left5, n_left5;
    logic               r_zero_seen, n_zero_seen;
    logic [IDX_W-1:0]   r_zero_row, n_zero_row;
    logic               r_out_valid, n_out_valid;

    // payload
    logic               r_cell_zero, n_cell_zero;
    logic [SUM_W-1:0]   r_ans, n_ans;
    logic               r_ch, n_ch;
    logic               r_zpath, n_zpath;
    logic [IDX_W-1:0]   r_zrow, n_zrow;
    logic               r_single, n_single;
    logic [MV_W-1:0]    r_nmoves, n_nmoves;
    logic [IDX_W-1:0]   r_tr, n_tr, r_tc, n_tc;
    logic [MV_W-1:0]    r_i, n_i, r_k, n_k;
    logic [SUM_W-1:0]   r_out_zc, n_out_zc;
    logic               r_out_move, n_out_move;
    logic               r_out_mv, n_out_mv;
    logic               r_out_last, n_out_last;

    // memories
    logic [2*SUM_W-1:0] r_row_mem [MAX_N];
    logic [1:0]         r_cfl_mem [CFL_DEPTH];
    logic               r_stk_mem [STK_DEPTH];
    logic [SUM_W-1:0]   r_up2, r_up5;
    logic [1:0]         r_cfl_q;
    logic               r_stk_q;

    logic               w_row_we, w_cfl_we, w_stk_we;
    logic [MV_W-1:0]    w_stk_addr;
    logic               w_stk_data;

    t_fac_res           w_fac;
    logic               w_start;

    logic [CFG_W-1:0]   w_gs_m1;
    logic [IDX_W-1:0]   w_n_m1;
    logic [MV_W-1:0]    w_nmoves_now;
    logic               w_first, w_last_cell;
    logic               w_l2, w_l5;
    logic [SUM_W-1:0]   w_s2, w_s5, w_ans;
    logic               w_zs;
    logic [IDX_W-1:0]   w_zr;
    logic               w_fl;
    logic [MV_W-1:0]    w_i_m1;
    logic               w_zmove, w_k_last, w_out_free;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    assign w_start    = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    gpmtz_factor u_factor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (i_cell_value),
        .o_res   (w_fac)
    );

    // effective side length minus one
    assign w_gs_m1 = r_grid_size - CFG_W'(1);
    always_comb begin
        if (r_grid_size == '0) begin
            w_n_m1 = '0;
        end else if (r_grid_size > CFG_W'(MAX_N)) begin
            w_n_m1 = IDX_W'(MAX_N - 1);
        end else begin
            w_n_m1 = w_gs_m1[IDX_W-1:0];
        end
    end
    assign w_nmoves_now = MV_W'({w_n_m1, 1'b0});

    // one DP cell, both channels; ties go to the left neighbor
    assign w_first     = (r_row == '0) && (r_col == '0);
    assign w_last_cell = (r_row == w_n_m1) && (r_col == w_n_m1);
    assign w_l2 = !w_first && ((r_row == '0) || ((r_col != '0) && (r_left2 <= r_up2)));
    assign w_l5 = !w_first && ((r_row == '0) || ((r_col != '0) && (r_left5 <= r_up5)));
    assign w_s2 = w_first ? SUM_W'(w_fac.twos)
                : (w_l2 ? sat_add(r_left2, w_fac.twos) : sat_add(r_up2, w_fac.twos));
    assign w_s5 = w_first ? SUM_W'(w_fac.fives)
                : (w_l5 ? sat_add(r_left5, w_fac.fives) : sat_add(r_up5, w_fac.fives));
    assign w_ans = (w_s2 <= w_s5) ? w_s2 : w_s5;
    assign w_zs  = r_zero_seen || r_cell_zero;
    assign w_zr  = r_cell_zero ? r_row : r_zero_row;

    // trace step: forced left on the top row, forced up on the left column
    always_comb begin
        if (r_tr == '0) begin
            w_fl = 1'b1;
        end else if (r_tc == '0) begin
            w_fl = 1'b0;
        end else begin
            w_fl = r_cfl_q[r_ch];
        end
    end
    assign w_i_m1 = r_i - MV_W'(1);

    // zero path: down to the zero row, right across, then down
    always_comb begin
        if (r_k < MV_W'(r_zrow)) begin
            w_zmove = 1'b1;
        end else if (r_k < (MV_W'(r_zrow) + MV_W'(w_n_m1))) begin
            w_zmove = 1'b0;
        end else begin
            w_zmove = 1'b1;
        end
    end
    assign w_k_last   = r_single || ((r_k + MV_W'(1)) == r_nmoves);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_row_we   = (r_state == S_FACT) && w_fac.done;
    assign w_cfl_we   = w_row_we;
    assign w_stk_we   = (r_state == S_TR_ST);
    assign w_stk_addr = w_i_m1;
    assign w_stk_data = !w_fl;

    always_comb begin
        n_state     = r_state;
        n_grid_size = r_grid_size;
        n_row       = r_row;
        n_col       = r_col;
        n_left2     = r_left2;
        n_left5     = r_left5;
        n_zero_seen = r_zero_seen;
        n_zero_row  = r_zero_row;
        n_out_valid = r_out_valid && !i_out_ready;
        n_cell_zero = r_cell_zero;
        n_ans       = r_ans;
        n_ch        = r_ch;
        n_zpath     = r_zpath;
        n_zrow      = r_zrow;
        n_single    = r_single;
        n_nmoves    = r_nmoves;
        n_tr        = r_tr;
        n_tc        = r_tc;
        n_i         = r_i;
        n_k         = r_k;
        n_out_zc    = r_out_zc;
        n_out_move  = r_out_move;
        n_out_mv    = r_out_mv;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cell_zero = (i_cell_value == '0);
                    n_state     = S_FACT;
                end
            end
            S_FACT: begin
                if (w_fac.done) begin
                    if (w_last_cell) begin
                        n_row       = '0;
                        n_col       = '0;
                        n_left2     = '0;
                        n_left5     = '0;
                        n_zero_seen = 1'b0;
                        n_zero_row  = '0;
                        n_ch        = (w_s2 > w_s5);
                        n_single    = (w_n_m1 == '0);
                        n_zpath     = (w_n_m1 != '0) && w_zs && (w_ans > SUM_W'(1));
                        n_zrow      = w_zr;
                        n_ans       = n_zpath ? SUM_W'(1) : w_ans;
                        n_nmoves    = w_nmoves_now;
                        n_tr        = w_n_m1;
                        n_tc        = w_n_m1;
                        n_i         = w_nmoves_now;
                        n_k         = '0;
                        n_state     = (n_single || n_zpath) ? S_EM_RD : S_TR_RD;
                    end else begin
                        n_left2     = w_s2;
                        n_left5     = w_s5;
                        n_zero_seen = w_zs;
                        n_zero_row  = w_zr;
                        if (r_col == w_n_m1) begin
                            n_col = '0;
                            n_row = r_row + IDX_W'(1);
                        end else begin
                            n_col = r_col + IDX_W'(1);
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_TR_RD: begin
                n_state = S_TR_ST;
            end
            S_TR_ST: begin
                n_i = w_i_m1;
                if (w_fl) begin
                    n_tc = r_tc - IDX_W'(1);
                end else begin
                    n_tr = r_tr - IDX_W'(1);
                end
                n_state = (w_i_m1 == '0) ? S_EM_RD : S_TR_RD;
            end
            S_EM_RD: begin
                n_state = S_EM_LD;
            end
            S_EM_LD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_zc    = r_ans;
                    n_out_mv    = !r_single;
                    n_out_last  = w_k_last;
                    if (r_single) begin
                        n_out_move = 1'b0;
                    end else if (r_zpath) begin
                        n_out_move = w_zmove;
                    end else begin
                        n_out_move = r_stk_q;
                    end
                    n_k     = r_k + MV_W'(1);
                    n_state = w_k_last ? S_IDLE : S_EM_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write restarts the grid being received
        if (i_cfg_we) begin
            n_grid_size = i_cfg_data;
            n_row       = '0;
            n_col       = '0;
            n_left2     = '0;
            n_left5     = '0;
            n_zero_seen = 1'b0;
            n_zero_row  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_size <= CFG_W'(MAX_N);
            r_row       <= '0;
            r_col       <= '0;
            r_left2     <= '0;
            r_left5     <= '0;
            r_zero_seen <= 1'b0;
            r_zero_row  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grid_size <= n_grid_size;
            r_row       <= n_row;
            r_col       <= n_col;
            r_left2     <= n_left2;
            r_left5     <= n_left5;
            r_zero_seen <= n_zero_seen;
            r_zero_row  <= n_zero_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell_zero <= n_cell_zero;
        r_ans       <= n_ans;
        r_ch        <= n_ch;
        r_zpath     <= n_zpath;
        r_zrow      <= n_zrow;
        r_single    <= n_single;
        r_nmoves    <= n_nmoves;
        r_tr        <= n_tr;
        r_tc        <= n_tc;
        r_i         <= n_i;
        r_k         <= n_k;
        r_out_zc    <= n_out_zc;
        r_out_move  <= n_out_move;
        r_out_mv    <= n_out_mv;
        r_out_last  <= n_out_last;
    end

    // row above: read on the cell transfer, written after the DP step
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_row_mem[r_col] <= {w_s2, w_s5};
        end
        if (w_start) begin
            {r_up2, r_up5} <= r_row_mem[r_col];
        end
    end

    // predecessor bits: bit 0 twos, bit 1 fives
    always_ff @(posedge i_clk) begin
        if (w_cfl_we) begin
            r_cfl_mem[{r_row, r_col}] <= {w_l5, w_l2};
        end
        r_cfl_q <= r_cfl_mem[{r_tr, r_tc}];
    end

    // traced moves, filled from the end, read front to back
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[w_stk_addr[STK_AW-1:0]] <= w_stk_data;
        end
        r_stk_q <= r_stk_mem[r_k[STK_AW-1:0]];
    end

    assign o_out_valid  = r_out_valid;
    assign o_zero_count = r_out_zc;
    assign o_move       = r_out_move;
    assign o_move_valid = r_out_mv;
    assign o_last       = r_out_last;

endmodule

>>> tb/tb.sv
// Testbench for grid_path_min_trailing_zeros: directed table and random grids.
`timescale 1ns / 100ps

module tb;
    import gpmtz_pkg::*;

    // ------------------------------------------------------------------
    // Run knobs
    // ------------------------------------------------------------------
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CELLS   = 12;      // partial 32x32 grid right after reset
    localparam int CLAMP_CELLS   = 8;       // partial grid at the clamped size
    localparam int RANDOM_CELLS  = 165;     // random cell transfers at small sizes
    localparam int CALM_CELLS    = 40;      // closing stretch with no idling
    localparam int SETTLE_CYCLES = 100;     // lets the factor unit finish a cell
    localparam int TAIL_CYCLES   = 300;     // margin after the last result
    localparam int RUN_LIMIT_NS  = 10_000_000;
    localparam longint unsigned VAL_MASK = (64'd1 << VALUE_BITS) - 64'd1;

    // One result transfer: count plus one path step.
    typedef struct packed {
        logic [SUM_W-1:0] zeros;
        logic             step;
        logic             step_ok;
        logic             tail;
    } move_t;

    // One row of the directed table. When typed is set, the single result
    // of a one-cell grid is spelled out in the row instead of predicted.
    typedef struct packed {
        logic                  cfg_first;
        logic [CFG_W-1:0]      cfg;
        logic [VALUE_BITS-1:0] word;
        logic                  typed;
        logic [SUM_W-1:0]      zeros;
    } probe_t;

    localparam int PLAN_LEN = 26;

    probe_t plan [PLAN_LEN] = '{
        // size 0 acts as 1; a zero cell costs one two and one five
        '{1'b1, 6'd0, 30'd0,          1'b1, 11'd1},
        '{1'b0, 6'd0, 30'd1,          1'b1, 11'd0},
        '{1'b0, 6'd0, 30'd1000,       1'b1, 11'd3},
        '{1'b0, 6'd0, 30'h3FFF_FFFF,  1'b1, 11'd0},
        '{1'b1, 6'd1, 30'h2000_0000,  1'b1, 11'd0},
        '{1'b0, 6'd1, 30'd1000000000, 1'b1, 11'd9},
        // 2x2: the best factor sum is 7, so the zero cell wins with 1
        '{1'b1, 6'd2, 30'd1000,       1'b0, 11'd0},
        '{1'b0, 6'd2, 30'd0,          1'b0, 11'd0},
        '{1'b0, 6'd2, 30'd1000,       1'b0, 11'd0},
        '{1'b0, 6'd2, 30'd1000,       1'b0, 11'd0},
        // 3x3 cut short by a config write: these three cells get dropped
        '{1'b1, 6'd3, 30'd7,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd2,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd5,          1'b0, 11'd0},
        // 3x3 of ones: every left/up pair ties, so left is taken throughout
        '{1'b1, 6'd3, 30'd1,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd1,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd1,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd1,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd1,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd1,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd1,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd1,          1'b0, 11'd0},
        '{1'b0, 6'd3, 30'd1,          1'b0, 11'd0},
        // 2x2 where the two channels tie: twos channel used
        '{1'b1, 6'd2, 30'd2,          1'b0, 11'd0},
        '{1'b0, 6'd2, 30'd5,          1'b0, 11'd0},
        '{1'b0, 6'd2, 30'd10,         1'b0, 11'd0},
        '{1'b0, 6'd2, 30'd1,          1'b0, 11'd0}
    };

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [VALUE_BITS-1:0] i_cell_value;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [SUM_W-1:0]      o_zero_count;
    logic                  o_move;
    logic                  o_move_valid;
    logic                  o_last;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    grid_path_min_trailing_zeros dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cell_value (i_cell_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_zero_count (o_zero_count),
        .o_move       (o_move),
        .o_move_valid (o_move_valid),
        .o_last       (o_last)
    );

    // ------------------------------------------------------------------
    // Path predictor state: its own copy of the size register and of the
    // grid being received. Per-cell factor counts are kept until the grid
    // is complete, then both min-sum recurrences run in one go.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] grid_cfg;
    int               cells_in;
    int               twos_at  [MAX_N][MAX_N];
    int               fives_at [MAX_N][MAX_N];
    bit               zero_hit;
    int               zero_line;

    move_t solved[$];       // results predicted for the cell just absorbed
    move_t moves_due[$];    // results predicted but not yet seen on the output
    move_t due;
    int    err_count = 0;

    // Idle knobs, percent chance of a burst per transfer (sender) or per
    // cycle (receiver). Zero gives back-to-back transfers.
    int gap_odds   = 0;
    int stall_odds = 0;

    function automatic int side_len(input logic [CFG_W-1:0] cfg);
        if (cfg == '0)
            return 1;
        if (cfg > MAX_N)
            return MAX_N;
        return int'(cfg);
    endfunction

    function automatic void clear_grid();
        cells_in  = 0;
        zero_hit  = 1'b0;
        zero_line = 0;
    endfunction

    // One channel of the recurrence; sums saturate, left wins a tie.
    function automatic int dp_step(input int r, input int c, input int cost,
                                   input int left, input int up,
                                   output bit from_left);
        int s;
        if (r == 0 && c == 0) begin
            from_left = 1'b0;
            return cost;
        end
        if (r == 0 || (c != 0 && left <= up)) begin
            from_left = 1'b1;
            s = left + cost;
        end else begin
            from_left = 1'b0;
            s = up + cost;
        end
        return (s > int'(SUM_MAX)) ? int'(SUM_MAX) : s;
    endfunction

    // Takes one accepted cell; fills solved when it completes the grid.
    function automatic void absorb_cell(input logic [VALUE_BITS-1:0] v);
        int                    side, r, c, k, t2, t5, best, nmoves, tr, tc, idx;
        logic [VALUE_BITS-1:0] t;
        int                    sum2  [MAX_N][MAX_N];
        int                    sum5  [MAX_N][MAX_N];
        bit                    from2 [MAX_N][MAX_N];
        bit                    from5 [MAX_N][MAX_N];
        bit                    steps [STK_DEPTH];
        bit                    use5, fl;

        side = side_len(grid_cfg);
        r    = cells_in / side;
        c    = cells_in % side;
        solved.delete();

        t2 = 0;
        t5 = 0;
        if (v == '0) begin
            t2        = 1;
            t5        = 1;
            zero_hit  = 1'b1;
            zero_line = r;
        end else begin
            t = v;
            while (!t[0]) begin
                t2++;
                t = t >> 1;
            end
            t = v;
            while (t % 5 == 0) begin
                t5++;
                t = t / 5;
            end
        end
        twos_at[r][c]  = t2;
        fives_at[r][c] = t5;
        cells_in++;
        if (cells_in < side * side)
            return;

        for (r = 0; r < side; r++) begin
            for (c = 0; c < side; c++) begin
                sum2[r][c] = dp_step(r, c, twos_at[r][c],
                                     (c > 0) ? sum2[r][c-1] : 0,
                                     (r > 0) ? sum2[r-1][c] : 0, from2[r][c]);
                sum5[r][c] = dp_step(r, c, fives_at[r][c],
                                     (c > 0) ? sum5[r][c-1] : 0,
                                     (r > 0) ? sum5[r-1][c] : 0, from5[r][c]);
            end
        end

        use5   = sum2[side-1][side-1] > sum5[side-1][side-1];
        best   = use5 ? sum5[side-1][side-1] : sum2[side-1][side-1];
        nmoves = 2 * (side - 1);

        if (side == 1) begin
            solved.push_back(move_t'{SUM_W'(best), 1'b0, 1'b0, 1'b1});
        end else begin
            if (best > 1 && zero_hit) begin
                // down to the zero's row, all the way right, then down
                best = 1;
                for (k = 0; k < nmoves; k++)
                    steps[k] = (k < zero_line) || (k >= zero_line + side - 1);
            end else begin
                tr  = side - 1;
                tc  = side - 1;
                idx = nmoves;
                while (tr != 0 || tc != 0) begin
                    fl = use5 ? from5[tr][tc] : from2[tr][tc];
                    if (tr == 0)
                        fl = 1'b1;
                    if (tc == 0)
                        fl = 1'b0;
                    idx--;
                    steps[idx] = !fl;
                    if (fl)
                        tc--;
                    else
                        tr--;
                end
            end
            for (k = 0; k < nmoves; k++)
                solved.push_back(move_t'{SUM_W'(best), steps[k], 1'b1,
                                         (k == nmoves - 1)});
        end
        clear_grid();
    endfunction

    // Cell mix: zeros at the given rate, raw 30-bit words, small values,
    // 2^a * 5^b products (deep factor counts), and words with low bits cleared.
    function automatic logic [VALUE_BITS-1:0] rand_cell(input int zero_pct);
        longint unsigned       p;
        int                    a, b;
        logic [VALUE_BITS-1:0] v;
        if ($urandom_range(1, 100) <= zero_pct)
            return '0;
        a = $urandom_range(0, 29);
        case ($urandom_range(0, 3))
            0: v = VALUE_BITS'($urandom);
            1: v = VALUE_BITS'($urandom_range(1, 250));
            2: begin
                p = 1;
                b = $urandom_range(0, 12);
                repeat (b) p = p * 5;
                while (a > 0 && (p << a) > VAL_MASK)
                    a--;
                v = VALUE_BITS'(p << a);
            end
            default: begin
                v = VALUE_BITS'($urandom);
                v = (v >> a) << a;
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Inputs move on the falling edge; a transfer is seen at
    // the rising edge where valid and ready are both high.
    // ------------------------------------------------------------------
    task automatic send_cell(input logic [VALUE_BITS-1:0] v);
        int gap;
        gap = ($urandom_range(1, 100) <= gap_odds) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_cell_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic feed_cell(input logic [VALUE_BITS-1:0] v);
        send_cell(v);
        absorb_cell(v);
        foreach (solved[j])
            moves_due.push_back(solved[j]);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Hold off until every predicted result has been taken, then let the
    // factor unit finish any cell of a partial grid.
    task automatic drain();
        while (moves_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        grid_cfg = value;
        clear_grid();
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: ready drops in random bursts while stall_odds > 0.
    // ------------------------------------------------------------------
    initial begin
        int hold;
        i_out_ready = 1'b0;
        forever begin
            if (stall_odds > 0 && $urandom_range(1, 100) <= stall_odds) begin
                hold = $urandom_range(1, 16);
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
        end
    end

    // Every result transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (moves_due.size() == 0) begin
                report_mismatch($sformatf("unpredicted result: zeros %0d move %0b last %0b",
                                          o_zero_count, o_move, o_last));
            end else begin
                due = moves_due.pop_front();
                if (o_zero_count !== due.zeros)
                    report_mismatch($sformatf("zero_count %0d, predicted %0d",
                                              o_zero_count, due.zeros));
                if (o_move !== due.step)
                    report_mismatch($sformatf("move %0b, predicted %0b",
                                              o_move, due.step));
                if (o_move_valid !== due.step_ok)
                    report_mismatch($sformatf("move_valid %0b, predicted %0b",
                                              o_move_valid, due.step_ok));
                if (o_last !== due.tail)
                    report_mismatch($sformatf("last %0b, predicted %0b",
                                              o_last, due.tail));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int  k, side, total, zp, random_cells;
        bit  restart_due, calm;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_cell_value = '0;
        grid_cfg     = CFG_W'(MAX_N);
        clear_grid();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Size after reset is 32: a few cells of a 32x32 grid with no write
        // first, dropped by the restarting write at the head of the table.
        gap_odds   = 5;
        stall_odds = 5;
        for (k = 0; k < RESET_CELLS; k++)
            feed_cell(rand_cell(2));

        // Directed table: extremes, zero cell, clamp of size 0, restart by a
        // config write, left-over-up ties, channel tie.
        gap_odds   = 20;
        stall_odds = 20;
        foreach (plan[i]) begin
            if (plan[i].cfg_first) begin
                end_burst();
                drain();
                cfg_write(plan[i].cfg);
            end
            send_cell(plan[i].word);
            absorb_cell(plan[i].word);
            if (plan[i].typed)
                moves_due.push_back(move_t'{plan[i].zeros, 1'b0, 1'b0, 1'b1});
            else
                foreach (solved[j])
                    moves_due.push_back(solved[j]);
        end

        // Size 63 clamps to 32; a partial grid, dropped by the next restart.
        end_burst();
        drain();
        cfg_write(6'h3F);
        gap_odds   = 5;
        stall_odds = 5;
        for (k = 0; k < CLAMP_CELLS; k++)
            feed_cell(rand_cell(0));

        // Random grids at small sizes. Now and then a grid is cut short,
        // and the next grid then starts with a restarting config write.
        random_cells = 0;
        restart_due  = 1'b1;
        while (random_cells < RANDOM_CELLS) begin
            calm       = (RANDOM_CELLS - random_cells) <= CALM_CELLS;
            gap_odds   = calm ? 0 : 15 * int'($urandom_range(0, 2));
            stall_odds = calm ? 0 : 15 * int'($urandom_range(0, 2));
            if (restart_due || (!calm && $urandom_range(0, 2) == 0)) begin
                end_burst();
                drain();
                k = $urandom_range(0, 99);
                if (k < 5)
                    cfg_write('0);
                else if (k < 12)
                    cfg_write(CFG_W'(1));
                else if (k < 85)
                    cfg_write(CFG_W'($urandom_range(2, 5)));
                else
                    cfg_write(CFG_W'($urandom_range(6, 8)));
                restart_due = 1'b0;
            end
            side  = side_len(grid_cfg);
            total = side * side;
            zp    = 10 * int'($urandom_range(0, 2));
            if (!calm && total > 1 && $urandom_range(0, 7) == 0) begin
                total       = $urandom_range(1, total - 1);
                restart_due = 1'b1;
            end
            for (k = 0; k < total; k++) begin
                feed_cell(rand_cell(zp));
                random_cells++;
            end
        end

        end_burst();
        while (moves_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> grid_path_min_trailing_zeros.f
hw/rtl/gpmtz_pkg.sv
hw/rtl/gpmtz_factor.sv
hw/rtl/grid_path_min_trailing_zeros.sv
tb/tb.sv
